### hw/rtl/ubx_pkg.sv
// Package for the UBX frame receiver: sync and message id constants,
// parser phase type and the capture control structure.
// No dependencies; imported by every module of the block.
package ubx_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    localparam logic [7:0] ID_VELOCITY = 8'h12;
    localparam logic [7:0] ID_TIME     = 8'h21;
    localparam logic [7:0] ID_POSITION = 8'h02;
    localparam logic [7:0] ID_STATUS   = 8'h03;

    localparam logic [1:0] KIND_VELOCITY = 2'd0;
    localparam logic [1:0] KIND_TIME     = 2'd1;
    localparam logic [1:0] KIND_POSITION = 2'd2;
    localparam logic [1:0] KIND_STATUS   = 2'd3;

    localparam logic [1:0] HDR_CLASS  = 2'd0;
    localparam logic [1:0] HDR_ID     = 2'd1;
    localparam logic [1:0] HDR_LEN_LO = 2'd2;
    localparam logic [1:0] HDR_LEN_HI = 2'd3;

    localparam int OUT_DATA_W = 104;
    localparam int OUT_USER_W = 3;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_HEAD,
        PH_BODY,
        PH_SUMA,
        PH_SUMB
    } t_phase;

    typedef struct packed {
        logic        en;
        logic [7:0]  msg_id;
        logic [15:0] index;
        logic [7:0]  data;
    } t_cap_ctl;

    function automatic logic id_known(input logic [7:0] id);
        return (id == ID_VELOCITY) || (id == ID_TIME) ||
               (id == ID_POSITION) || (id == ID_STATUS);
    endfunction

    function automatic logic [1:0] kind_of(input logic [7:0] id);
        logic [1:0] k;
        case (id)
            ID_TIME:     k = KIND_TIME;
            ID_POSITION: k = KIND_POSITION;
            ID_STATUS:   k = KIND_STATUS;
            default:     k = KIND_VELOCITY;
        endcase
        return k;
    endfunction

endpackage

### hw/rtl/ubx_parser.sv
// Frame parser: sync hunt, header decode, Fletcher-8 sums and checksum check.
// Depends on ubx_pkg; drives the capture control for ubx_capture.
module ubx_parser
    import ubx_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output logic       o_res_valid,
    output logic [1:0] o_kind,
    output logic       o_ck_ok,
    output t_cap_ctl   o_cap
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_prev, n_prev;
    logic [1:0]  r_hidx, n_hidx;
    logic [7:0]  r_id, n_id;
    logic [15:0] r_len, n_len;
    logic [15:0] r_pidx, n_pidx;
    logic [7:0]  r_sum_a, n_sum_a;
    logic [7:0]  r_sum_b, n_sum_b;
    logic [7:0]  r_rx_a, n_rx_a;
    logic [7:0]  w_add_a;
    logic [15:0] w_len_full;
    logic [15:0] w_pidx_inc;

    assign w_add_a    = r_sum_a + i_byte;
    assign w_len_full = {i_byte, r_len[7:0]};
    assign w_pidx_inc = r_pidx + 16'd1;

    always_comb begin
        n_phase = r_phase;
        if (i_step) begin
            case (r_phase)
                PH_HUNT: begin
                    if (i_byte == SYNC_SECOND && r_prev == SYNC_FIRST) begin
                        n_phase = PH_HEAD;
                    end
                end
                PH_HEAD: begin
                    if (r_hidx == HDR_LEN_HI) begin
                        if (!id_known(r_id)) begin
                            n_phase = PH_HUNT;
                        end else if (w_len_full == 16'd0) begin
                            n_phase = PH_SUMA;
                        end else begin
                            n_phase = PH_BODY;
                        end
                    end
                end
                PH_BODY: begin
                    if (w_pidx_inc == r_len) begin
                        n_phase = PH_SUMA;
                    end
                end
                PH_SUMA: n_phase = PH_SUMB;
                PH_SUMB: n_phase = PH_HUNT;
                default: n_phase = PH_HUNT;
            endcase
        end
    end

    always_comb begin
        n_prev  = r_prev;
        n_hidx  = r_hidx;
        n_id    = r_id;
        n_len   = r_len;
        n_pidx  = r_pidx;
        n_sum_a = r_sum_a;
        n_sum_b = r_sum_b;
        n_rx_a  = r_rx_a;
        o_res_valid = 1'b0;
        o_cap.en     = 1'b0;
        o_cap.msg_id = r_id;
        o_cap.index  = r_pidx;
        o_cap.data   = i_byte;
        if (i_step) begin
            case (r_phase)
                PH_HUNT: begin
                    if (i_byte == SYNC_SECOND && r_prev == SYNC_FIRST) begin
                        n_hidx  = HDR_CLASS;
                        n_sum_a = 8'd0;
                        n_sum_b = 8'd0;
                    end
                    n_prev = i_byte;
                end
                PH_HEAD: begin
                    n_sum_a = w_add_a;
                    n_sum_b = r_sum_b + w_add_a;
                    case (r_hidx)
                        HDR_ID:     n_id = i_byte;
                        HDR_LEN_LO: n_len = {8'd0, i_byte};
                        HDR_LEN_HI: begin
                            n_len  = w_len_full;
                            n_pidx = 16'd0;
                        end
                        default: ;
                    endcase
                    n_hidx = r_hidx + 2'd1;
                end
                PH_BODY: begin
                    n_sum_a  = w_add_a;
                    n_sum_b  = r_sum_b + w_add_a;
                    o_cap.en = 1'b1;
                    n_pidx   = w_pidx_inc;
                end
                PH_SUMA: n_rx_a = i_byte;
                PH_SUMB: o_res_valid = 1'b1;
                default: ;
            endcase
        end
    end

    assign o_kind  = kind_of(r_id);
    assign o_ck_ok = (r_sum_a == r_rx_a) && (r_sum_b == i_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_prev  <= 8'd0;
            r_hidx  <= 2'd0;
            r_id    <= 8'd0;
            r_len   <= 16'd0;
            r_pidx  <= 16'd0;
            r_sum_a <= 8'd0;
            r_sum_b <= 8'd0;
            r_rx_a  <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_prev  <= n_prev;
            r_hidx  <= n_hidx;
            r_id    <= n_id;
            r_len   <= n_len;
            r_pidx  <= n_pidx;
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
            r_rx_a  <= n_rx_a;
        end
    end

endmodule

### hw/rtl/ubx_capture.sv
// Fixed-offset field capture: assembles little-endian payload fields and
// holds the latest value of each. Depends on ubx_pkg.
module ubx_capture
    import ubx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cap_ctl    i_cap,
    output logic [15:0] o_ground_speed,
    output logic [15:0] o_year_value,
    output logic [31:0] o_height_msl,
    output logic [7:0]  o_fix_status,
    output logic [31:0] o_ms_since_start
);

    logic [23:0] r_word, n_word;
    logic [15:0] r_speed, n_speed;
    logic [15:0] r_year, n_year;
    logic [31:0] r_height, n_height;
    logic [7:0]  r_fix, n_fix;
    logic [31:0] r_ms, n_ms;

    always_comb begin
        n_word   = r_word;
        n_speed  = r_speed;
        n_year   = r_year;
        n_height = r_height;
        n_fix    = r_fix;
        n_ms     = r_ms;
        if (i_cap.en) begin
            case (i_cap.msg_id)
                ID_VELOCITY: begin
                    if (i_cap.index == 16'd20) n_word[7:0] = i_cap.data;
                    if (i_cap.index == 16'd21) n_speed = {i_cap.data, r_word[7:0]};
                end
                ID_TIME: begin
                    if (i_cap.index == 16'd12) n_word[7:0] = i_cap.data;
                    if (i_cap.index == 16'd13) n_year = {i_cap.data, r_word[7:0]};
                end
                ID_POSITION: begin
                    if (i_cap.index == 16'd16) n_word[7:0]   = i_cap.data;
                    if (i_cap.index == 16'd17) n_word[15:8]  = i_cap.data;
                    if (i_cap.index == 16'd18) n_word[23:16] = i_cap.data;
                    if (i_cap.index == 16'd19) n_height = {i_cap.data, r_word};
                end
                ID_STATUS: begin
                    if (i_cap.index == 16'd6)  n_fix = i_cap.data;
                    if (i_cap.index == 16'd12) n_word[7:0]   = i_cap.data;
                    if (i_cap.index == 16'd13) n_word[15:8]  = i_cap.data;
                    if (i_cap.index == 16'd14) n_word[23:16] = i_cap.data;
                    if (i_cap.index == 16'd15) n_ms = {i_cap.data, r_word};
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed  <= 16'd0;
            r_year   <= 16'd0;
            r_height <= 32'd0;
            r_fix    <= 8'd0;
            r_ms     <= 32'd0;
        end else begin
            r_speed  <= n_speed;
            r_year   <= n_year;
            r_height <= n_height;
            r_fix    <= n_fix;
            r_ms     <= n_ms;
        end
    end

    assign o_ground_speed   = r_speed;
    assign o_year_value     = r_year;
    assign o_height_msl     = r_height;
    assign o_fix_status     = r_fix;
    assign o_ms_since_start = r_ms;

endmodule

### hw/rtl/ubx_frame_receiver_unit.sv
// UBX frame receiver top level: input register, parser, field capture and a
// two-entry result buffer. Depends on ubx_pkg, ubx_parser and ubx_capture.
// Throughput is one byte per cycle unless both result slots are full; the CK_B
// byte passes the input register, then its result is registered for m_tvalid.
// The parser stalls only while both result slots are full.
// Synchronous active-low reset returns to sync hunting with all captured field values zero.
module ubx_frame_receiver_unit
    import ubx_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,  // data_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // msg_kind[1:0], checksum_ok[2]
    output logic [OUT_USER_W-1:0] m_tuser,
    // ground_speed[15:0], year_value[31:16], height_msl[63:32],
    // fix_status[71:64], ms_since_start[103:72]
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_out_valid;
    logic [OUT_USER_W-1:0] r_out_user;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_skid_valid;
    logic [OUT_USER_W-1:0] r_skid_user;
    logic [OUT_DATA_W-1:0] r_skid_data;
    logic                  w_adv;
    logic                  w_step;
    logic                  w_pop;
    logic                  w_res_valid;
    logic [1:0]            w_kind;
    logic                  w_ck_ok;
    t_cap_ctl              w_cap;
    logic [15:0]           w_speed;
    logic [15:0]           w_year;
    logic [31:0]           w_height;
    logic [7:0]            w_fix;
    logic [31:0]           w_ms;
    logic [OUT_USER_W-1:0] w_res_user;
    logic [OUT_DATA_W-1:0] w_res_data;

    assign w_adv    = !r_skid_valid;
    assign w_step   = r_in_valid && w_adv;
    assign s_tready = !r_in_valid || w_adv;
    assign w_pop    = r_out_valid && m_tready;

    ubx_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_byte      (r_in_byte),
        .o_res_valid (w_res_valid),
        .o_kind      (w_kind),
        .o_ck_ok     (w_ck_ok),
        .o_cap       (w_cap)
    );

    ubx_capture u_capture (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cap            (w_cap),
        .o_ground_speed   (w_speed),
        .o_year_value     (w_year),
        .o_height_msl     (w_height),
        .o_fix_status     (w_fix),
        .o_ms_since_start (w_ms)
    );

    assign w_res_user = {w_ck_ok, w_kind};
    assign w_res_data = {w_ms, w_fix, w_height, w_year, w_speed};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready) begin
            r_in_byte <= s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || w_pop) begin
                r_out_valid <= r_skid_valid || w_res_valid;
            end
            if (r_skid_valid) begin
                r_skid_valid <= !w_pop;
            end else begin
                r_skid_valid <= w_res_valid && r_out_valid && !w_pop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_pop) begin
            if (r_skid_valid) begin
                r_out_user <= r_skid_user;
                r_out_data <= r_skid_data;
            end else if (w_res_valid) begin
                r_out_user <= w_res_user;
                r_out_data <= w_res_data;
            end
        end
        if (!r_skid_valid && w_res_valid && r_out_valid && !w_pop) begin
            r_skid_user <= w_res_user;
            r_skid_data <= w_res_data;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out_user;
    assign m_tdata  = r_out_data;

`ifndef SYNTH
    a_result_needs_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> w_step)
        else $error("parser produced a result without a byte");

    a_result_registered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |=> m_tvalid)
        else $error("result lost before the output register");

    a_no_step_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !w_step)
        else $error("parser stepped while both result slots were full");
`endif

endmodule
